>>> hdl/lscs_pkg.sv
// Shared types and constants for the line sensor calibrate and steer block.
package lscs_pkg;
  localparam int unsigned LEVEL_FULL = 1000;

  typedef enum logic [2:0] {
    ACT_HOLD   = 3'd0,
    ACT_FWD    = 3'd1,
    ACT_RIGHT  = 3'd2,
    ACT_LEFT   = 3'd3,
    ACT_RFAST  = 3'd4,
    ACT_LFAST  = 3'd5,
    ACT_CROSS  = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_FAST      = 3'd1,
    REG_MEDIUM    = 3'd2,
    REG_SLOW      = 3'd3,
    REG_CAL       = 3'd4,
    REG_INVERT    = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_NEXT = 2'd2,
    BK_OUT  = 2'd3
  } back_state_t;

  typedef struct packed {
    logic [9:0] threshold;
    logic [7:0] fast_duty;
    logic [7:0] medium_duty;
    logic [7:0] slow_duty;
    logic       calibrating;
    logic       invert_line;
  } cfg_t;
endpackage

>>> hdl/lscs_front.sv
// Front end: accumulates frames, forms rounded averages and queues them.
module lscs_front import lscs_pkg::*; #(
  parameter int SAMPLES = 4,
  parameter int AW = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  logic [9:0]      sample [5],
  output logic            q_valid,
  input  logic            q_take,
  output logic [AW-1:0]   q_avg [5]
);
  localparam int SW = 10 + $clog2(SAMPLES + 1);
  localparam int FW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  // The average uses a reciprocal multiplication, exact for totals below 2**14.
  localparam int RS = 18;
  localparam int unsigned RM = ((1 << RS) + SAMPLES - 1) / SAMPLES;
  localparam int PW = SW + 21;

  logic [SW-1:0] sum_r [5];
  logic [FW-1:0] cnt_r;
  // Two entry queue of completed averages.
  logic [AW-1:0] qd_r [2][5];
  logic [1:0]    qn_r;
  logic          wp_r, rp_r;
  logic          acc, last;
  logic [SW+1:0] tot [5];
  logic [PW-1:0] prod [5];

  assign full = (qn_r == 2'd2);
  assign acc  = push && !full;
  assign last = (SAMPLES == 1) || (cnt_r == FW'(SAMPLES - 1));
  assign q_valid = (qn_r != 2'd0);
  always_comb begin
    for (int i = 0; i < 5; i++) q_avg[i] = qd_r[rp_r][i];
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      tot[i]  = {2'b0, sum_r[i]} + (SW + 2)'(sample[i]) + (SW + 2)'(SAMPLES / 2);
      prod[i] = PW'(tot[i]) * PW'(RM);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      qn_r  <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      for (int i = 0; i < 5; i++) sum_r[i] <= '0;
    end else begin
      if (acc) begin
        if (last) begin
          cnt_r <= '0;
          wp_r  <= !wp_r;
          for (int i = 0; i < 5; i++) begin
            sum_r[i] <= '0;
            qd_r[wp_r][i] <= AW'(prod[i] >> RS);
          end
        end else begin
          cnt_r <= cnt_r + 1'b1;
          for (int i = 0; i < 5; i++) sum_r[i] <= sum_r[i] + SW'(sample[i]);
        end
      end
      if (q_take) rp_r <= !rp_r;
      qn_r <= qn_r + {1'b0, acc && last} - {1'b0, q_take};
    end
  end
endmodule

>>> hdl/lscs_div.sv
// Restoring divider, one quotient bit per cycle.
module lscs_div #(
  parameter int NW = 22,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] d_r;
  logic [CW-1:0] n_r;
  logic [DW:0]   sh;

  assign sh   = {rem_r[DW-1:0], q_r[NW-1]};
  assign quo  = q_r;
  assign done = (n_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
    end else if (start) begin
      q_r   <= num;
      rem_r <= '0;
      d_r   <= den;
      n_r   <= CW'(NW);
    end else if (n_r != '0) begin
      n_r <= n_r - 1'b1;
      if (sh >= {1'b0, d_r}) begin
        rem_r <= sh - {1'b0, d_r};
        q_r   <= {q_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= sh;
        q_r   <= {q_r[NW-2:0], 1'b0};
      end
    end
  end
endmodule

>>> hdl/lscs_back.sv
// Back end: calibration range, normalization through a shared divider, steering.
module lscs_back import lscs_pkg::*; #(
  parameter int AW = 10,
  parameter int ADC_MAX = 1023
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          q_valid,
  output logic          q_take,
  input  logic [AW-1:0] q_avg [5],
  output logic          o_valid,
  input  logic          o_pop,
  output logic [2:0]    o_action,
  output logic          o_ldir,
  output logic [7:0]    o_lduty,
  output logic          o_rdir,
  output logic [7:0]    o_rduty,
  output logic [9:0]    o_level [5]
);
  localparam int NW = AW + 10;

  back_state_t st_r, st_nxt;
  logic [AW-1:0] mn_r [5];
  logic [AW-1:0] mx_r [5];
  logic [9:0]    lv_r [5];
  logic [2:0]    idx_r;
  logic [17:0]   last_r;
  logic          ov_r;
  logic [2:0]    act_r;
  logic [17:0]   drv_r;

  logic [AW-1:0] a, lo, hi;
  logic          zero;
  logic          dstart, ddone;
  logic [NW-1:0] quo;
  logic [9:0]    lvn;

  assign a  = q_avg[idx_r];
  assign lo = mn_r[idx_r];
  assign hi = mx_r[idx_r];
  assign zero = (hi <= lo) || (a <= lo);

  lscs_div #(.NW(NW), .DW(AW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart),
    .num(NW'(a - lo) * NW'(LEVEL_FULL)), .den(hi - lo),
    .done(ddone), .quo(quo)
  );

  always_comb begin
    logic [9:0] v;
    if (zero) v = '0;
    else if (quo > NW'(LEVEL_FULL)) v = 10'(LEVEL_FULL);
    else v = quo[9:0];
    lvn = cfg.invert_line ? 10'(LEVEL_FULL) - v : v;
  end

  // Steering decision from the finished levels.
  logic [2:0]  act;
  logic [17:0] drv;
  always_comb begin
    logic g1, l1, g2, l2, g3, l3;
    logic [9:0] t;
    t  = cfg.threshold;
    g1 = lv_r[1] > t; l1 = lv_r[1] < t;
    g2 = lv_r[2] > t; l2 = lv_r[2] < t;
    g3 = lv_r[3] > t; l3 = lv_r[3] < t;
    act = ACT_HOLD;
    drv = last_r;
    if (g1 && l2 && g3) begin
      act = ACT_FWD; drv = {1'b0, cfg.medium_duty, 1'b1, cfg.medium_duty};
    end else if (l1 && g2 && g3) begin
      act = ACT_RIGHT; drv = {1'b0, cfg.medium_duty, 1'b0, 8'd0};
    end else if (g1 && g2 && l3) begin
      act = ACT_LEFT; drv = {1'b1, 8'd0, 1'b1, cfg.medium_duty};
    end else if (l1 && l2 && g3) begin
      act = ACT_RFAST; drv = {1'b0, cfg.fast_duty, 1'b0, 8'd0};
    end else if (g1 && l2 && l3) begin
      act = ACT_LFAST; drv = {1'b1, 8'd0, 1'b1, cfg.fast_duty};
    end else if (lv_r[0] < t && l1 && l2 && l3 && lv_r[4] < t) begin
      act = ACT_CROSS; drv = {1'b0, cfg.slow_duty, 1'b1, cfg.slow_duty};
    end
  end

  always_comb begin
    st_nxt = st_r;
    dstart = 1'b0;
    q_take = 1'b0;
    case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (cfg.calibrating) q_take = 1'b1;
          else if (!ov_r) begin
            dstart = 1'b1;
            st_nxt = BK_DIV;
          end
        end
      end
      BK_DIV: if (ddone) st_nxt = (idx_r == 3'd4) ? BK_OUT : BK_NEXT;
      BK_NEXT: begin
        dstart = 1'b1;
        st_nxt = BK_DIV;
      end
      BK_OUT: begin
        q_take = 1'b1;
        st_nxt = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_IDLE;
      idx_r  <= '0;
      ov_r   <= 1'b0;
      last_r <= '0;
      for (int i = 0; i < 5; i++) begin
        mn_r[i] <= AW'(ADC_MAX);
        mx_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (o_valid && o_pop) ov_r <= 1'b0;
      if (st_r == BK_IDLE && q_valid && cfg.calibrating) begin
        for (int i = 0; i < 5; i++) begin
          if (q_avg[i] < mn_r[i]) mn_r[i] <= q_avg[i];
          if (q_avg[i] > mx_r[i]) mx_r[i] <= q_avg[i];
        end
      end
      if (st_r == BK_DIV && ddone) begin
        lv_r[idx_r] <= lvn;
        idx_r <= (idx_r == 3'd4) ? 3'd0 : idx_r + 1'b1;
      end
      if (st_r == BK_OUT) begin
        ov_r  <= 1'b1;
        act_r <= act;
        drv_r <= drv;
        last_r <= (act == ACT_CROSS) ?
                  {1'b0, cfg.medium_duty, 1'b1, cfg.medium_duty} : drv;
      end
    end
  end

  assign o_valid  = ov_r;
  assign o_action = act_r;
  assign {o_ldir, o_lduty, o_rdir, o_rduty} = drv_r;
  always_comb begin
    for (int i = 0; i < 5; i++) o_level[i] = lv_r[i];
  end

  a_out_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_OUT) |-> !ov_r) else $error("result register overwritten");
  a_take_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid) else $error("take from empty queue");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !o_pop) |=> (ov_r && $stable(act_r))) else $error("result lost");
endmodule

>>> hdl/line_sensor_calibrate_steer.sv
// Top level of the line sensor calibrate and steer block.
// Usage: push one frame of five raw samples per beat on the in_ ports while
// full is low. Every SAMPLES frames the front end forms rounded averages and
// queues them (two entries). In calibrate mode an average set only widens the
// per-sensor min/max and gives no result. In run mode the back end normalizes
// each sensor in turn through one shared restoring divider (20 quotient
// steps), then puts one steering beat per average set in the result
// register, shown while out_empty is low and taken by out_pop. It starts
// on an average set only while the result register is empty.
// Frames are accepted while the queue has room; full rises when two average
// sets wait, e.g. while the receiver stalls. Reset: sums cleared, min 1023,
// max 0, held drive stopped, registers at their defaults. The user must write
// configuration over APB only while idle; the block does not enforce it.
module line_sensor_calibrate_steer import lscs_pkg::*; #(
  parameter int SAMPLES = 4,
  parameter int ADC_MAX = 1023
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [9:0]  in_sample_a,
  input  logic [9:0]  in_sample_b,
  input  logic [9:0]  in_sample_c,
  input  logic [9:0]  in_sample_d,
  input  logic [9:0]  in_sample_e,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_action,
  output logic        out_left_dir_level,
  output logic [7:0]  out_left_duty,
  output logic        out_right_dir_level,
  output logic [7:0]  out_right_duty,
  output logic [9:0]  out_level_a,
  output logic [9:0]  out_level_b,
  output logic [9:0]  out_level_c,
  output logic [9:0]  out_level_d,
  output logic [9:0]  out_level_e,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int AW = $clog2(ADC_MAX + 1);

  cfg_t cfg_r;
  logic [2:0] ridx;
  assign ridx = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{threshold: 10'd200, fast_duty: 8'd100, medium_duty: 8'd80,
                 slow_duty: 8'd70, calibrating: 1'b1, invert_line: 1'b0};
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (ridx)
        REG_THRESHOLD: cfg_r.threshold   <= cfg_pwdata[9:0];
        REG_FAST:      cfg_r.fast_duty   <= cfg_pwdata[7:0];
        REG_MEDIUM:    cfg_r.medium_duty <= cfg_pwdata[7:0];
        REG_SLOW:      cfg_r.slow_duty   <= cfg_pwdata[7:0];
        REG_CAL:       cfg_r.calibrating <= cfg_pwdata[0];
        REG_INVERT:    cfg_r.invert_line <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_THRESHOLD: cfg_prdata = {22'd0, cfg_r.threshold};
      REG_FAST:      cfg_prdata = {24'd0, cfg_r.fast_duty};
      REG_MEDIUM:    cfg_prdata = {24'd0, cfg_r.medium_duty};
      REG_SLOW:      cfg_prdata = {24'd0, cfg_r.slow_duty};
      REG_CAL:       cfg_prdata = {31'd0, cfg_r.calibrating};
      REG_INVERT:    cfg_prdata = {31'd0, cfg_r.invert_line};
      default:       cfg_prdata = '0;
    endcase
  end

  logic [9:0]    smp [5];
  logic [AW-1:0] qa [5];
  logic [9:0]    lvl [5];
  logic          qv, qt, ov;
  assign smp[0] = in_sample_a;
  assign smp[1] = in_sample_b;
  assign smp[2] = in_sample_c;
  assign smp[3] = in_sample_d;
  assign smp[4] = in_sample_e;

  lscs_front #(.SAMPLES(SAMPLES), .AW(AW)) u_front (
    .clk(clk), .rst_n(rst_n), .push(in_push), .full(in_full), .sample(smp),
    .q_valid(qv), .q_take(qt), .q_avg(qa)
  );

  lscs_back #(.AW(AW), .ADC_MAX(ADC_MAX)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(qv), .q_take(qt),
    .q_avg(qa), .o_valid(ov), .o_pop(out_pop), .o_action(out_action),
    .o_ldir(out_left_dir_level), .o_lduty(out_left_duty),
    .o_rdir(out_right_dir_level), .o_rduty(out_right_duty), .o_level(lvl)
  );

  assign out_empty = !ov;
  assign out_level_a = lvl[0];
  assign out_level_b = lvl[1];
  assign out_level_c = lvl[2];
  assign out_level_d = lvl[3];
  assign out_level_e = lvl[4];
endmodule

>>> sim/tb_line_sensor_calibrate_steer.sv
// Testbench for the line sensor calibrate and steer block: predictor, stimulus and checks.
`timescale 1ns / 100ps

module tb_line_sensor_calibrate_steer;
  import lscs_pkg::*;

  localparam int NSENS = 5;
  localparam int FRAMES_PER_AVG = 4;
  localparam int ADC_TOP = 1023;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [2:0] action;
    logic       ldir;
    logic [7:0] lduty;
    logic       rdir;
    logic [7:0] rduty;
    logic [9:0] lv_a, lv_b, lv_c, lv_d, lv_e;
  } steer_t;

  typedef logic [9:0] frame_t [NSENS];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [9:0] in_sample_a = '0, in_sample_b = '0, in_sample_c = '0;
  logic [9:0] in_sample_d = '0, in_sample_e = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [2:0] out_action;
  logic out_left_dir_level, out_right_dir_level;
  logic [7:0] out_left_duty, out_right_duty;
  logic [9:0] out_level_a, out_level_b, out_level_c, out_level_d, out_level_e;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  line_sensor_calibrate_steer u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor copy of the block's registers and state.
  logic [9:0] p_thresh;
  logic [7:0] p_fast, p_med, p_slow;
  logic p_cal, p_inv;
  logic [11:0] p_sums [NSENS];
  int unsigned p_frames;
  logic [9:0] p_min [NSENS];
  logic [9:0] p_max [NSENS];
  logic [17:0] p_drive;  // {ldir, lduty, rdir, rduty}

  steer_t steer_q[$];
  int mismatches = 0;
  int checked = 0;
  int sent = 0;
  int burst_left = 0;
  int stall_hold = 0;  // when nonzero the receiver holds off this many cycles
  bit long_stall_req = 0;

  function automatic logic [9:0] scale_level(logic [9:0] avg, logic [9:0] lo, logic [9:0] hi);
    int unsigned v;
    if (hi <= lo || avg <= lo) return 10'd0;
    v = ((avg - lo) * LEVEL_FULL) / (hi - lo);
    return (v > LEVEL_FULL) ? 10'(LEVEL_FULL) : 10'(v);
  endfunction

  task automatic predict_frame(input frame_t f);
    logic [9:0] avg [NSENS];
    logic [9:0] lv [NSENS];
    logic g1, l1, g2, l2, g3, l3;
    logic [17:0] drv;
    action_t act;
    steer_t r;
    for (int i = 0; i < NSENS; i++) p_sums[i] += f[i];
    p_frames++;
    if (p_frames < FRAMES_PER_AVG) return;
    p_frames = 0;
    for (int i = 0; i < NSENS; i++) begin
      avg[i] = 10'((p_sums[i] + FRAMES_PER_AVG / 2) / FRAMES_PER_AVG);
      p_sums[i] = '0;
    end
    if (p_cal) begin
      for (int i = 0; i < NSENS; i++) begin
        if (avg[i] < p_min[i]) p_min[i] = avg[i];
        if (avg[i] > p_max[i]) p_max[i] = avg[i];
      end
      return;
    end
    for (int i = 0; i < NSENS; i++) begin
      lv[i] = scale_level(avg[i], p_min[i], p_max[i]);
      if (p_inv) lv[i] = 10'(LEVEL_FULL) - lv[i];
    end
    g1 = lv[1] > p_thresh; l1 = lv[1] < p_thresh;
    g2 = lv[2] > p_thresh; l2 = lv[2] < p_thresh;
    g3 = lv[3] > p_thresh; l3 = lv[3] < p_thresh;
    drv = p_drive;
    act = ACT_HOLD;
    if (g1 && l2 && g3) begin
      act = ACT_FWD; drv = {1'b0, p_med, 1'b1, p_med};
    end else if (l1 && g2 && g3) begin
      act = ACT_RIGHT; drv = {1'b0, p_med, 1'b0, 8'd0};
    end else if (g1 && g2 && l3) begin
      act = ACT_LEFT; drv = {1'b1, 8'd0, 1'b1, p_med};
    end else if (l1 && l2 && g3) begin
      act = ACT_RFAST; drv = {1'b0, p_fast, 1'b0, 8'd0};
    end else if (g1 && l2 && l3) begin
      act = ACT_LFAST; drv = {1'b1, 8'd0, 1'b1, p_fast};
    end else if (lv[0] < p_thresh && l1 && l2 && l3 && lv[4] < p_thresh) begin
      act = ACT_CROSS; drv = {1'b0, p_slow, 1'b1, p_slow};
    end
    // A crossing is driven slow but the held drive afterwards is forward medium.
    p_drive = (act == ACT_CROSS) ? {1'b0, p_med, 1'b1, p_med} : drv;
    r = {act, drv, lv[0], lv[1], lv[2], lv[3], lv[4]};
    steer_q.push_back(r);
  endtask

  task automatic reset_predictor();
    p_thresh = 10'd200; p_fast = 8'd100; p_med = 8'd80; p_slow = 8'd70;
    p_cal = 1'b1; p_inv = 1'b0; p_frames = 0; p_drive = '0;
    for (int i = 0; i < NSENS; i++) begin
      p_sums[i] = '0; p_min[i] = 10'(ADC_TOP); p_max[i] = '0;
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_paddr = 5'(idx) << 2; cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    case (idx)
      REG_THRESHOLD: p_thresh = val[9:0];
      REG_FAST:      p_fast = val[7:0];
      REG_MEDIUM:    p_med = val[7:0];
      REG_SLOW:      p_slow = val[7:0];
      REG_CAL:       p_cal = val[0];
      REG_INVERT:    p_inv = val[0];
      default: ;
    endcase
  endtask

  // Sends one frame, keeping push high across back-to-back beats.
  task automatic send_frame(input frame_t f, input bit gaps);
    if (gaps) begin
      if (burst_left == 0) begin
        in_push = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    in_sample_a = f[0]; in_sample_b = f[1]; in_sample_c = f[2];
    in_sample_d = f[3]; in_sample_e = f[4];
    in_push = 1'b1;
    do @(posedge clk); while (in_full);
    predict_frame(f);
    sent++;
    @(negedge clk);
    in_push = 1'b0;
  endtask

  task automatic drain_and_settle();
    in_push = 1'b0;
    while (steer_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sends one average set of frames all equal to f.
  task automatic send_set(input frame_t f, input bit gaps);
    repeat (FRAMES_PER_AVG) send_frame(f, gaps);
  endtask

  function automatic frame_t rand_frame(input int lo, input int hi);
    frame_t f;
    for (int i = 0; i < NSENS; i++) f[i] = 10'($urandom_range(lo, hi));
    return f;
  endfunction

  // Receiver: random stall pattern, plus a long hold when requested.
  always @(negedge clk) begin
    if (long_stall_req && stall_hold == 0) begin
      stall_hold = 400;
      long_stall_req = 0;
    end
    if (stall_hold > 0) begin
      stall_hold--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(0, 3) != 0) || sent[8];
    end
  end

  always @(posedge clk) begin
    steer_t got, want;
    if (rst_n && out_pop && !out_empty) begin
      got = {out_action, out_left_dir_level, out_left_duty, out_right_dir_level,
             out_right_duty, out_level_a, out_level_b, out_level_c, out_level_d,
             out_level_e};
      if (steer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = steer_q.pop_front();
        checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: expected act %0d drv %h lv %0d %0d %0d %0d %0d, got act %0d drv %h lv %0d %0d %0d %0d %0d",
                     checked, want.action, want[67:50], want.lv_a, want.lv_b, want.lv_c,
                     want.lv_d, want.lv_e, got.action, got[67:50], got.lv_a, got.lv_b,
                     got.lv_c, got.lv_d, got.lv_e);
        end
      end
    end
  end

  // Calibrates each sensor over a known range of dark and bright averages.
  task automatic test_calibration();
    frame_t f;
    write_reg(REG_CAL, 32'd1);
    f = '{10'd100, 10'd100, 10'd100, 10'd100, 10'd100};
    send_set(f, 0);
    f = '{10'd900, 10'd900, 10'd900, 10'd900, 10'd900};
    send_set(f, 0);
    drain_and_settle();
    write_reg(REG_CAL, 32'd0);
  endtask

  // Directed frames hitting each steering rule, hold, and clamp at the range ends.
  task automatic test_directed_rules();
    frame_t f;
    f = '{10'd100, 10'd900, 10'd100, 10'd900, 10'd100}; send_set(f, 0);  // forward
    f = '{10'd100, 10'd100, 10'd900, 10'd900, 10'd100}; send_set(f, 0);  // right
    f = '{10'd100, 10'd900, 10'd900, 10'd100, 10'd100}; send_set(f, 0);  // left
    f = '{10'd100, 10'd100, 10'd100, 10'd900, 10'd100}; send_set(f, 0);  // right fast
    f = '{10'd100, 10'd900, 10'd100, 10'd100, 10'd100}; send_set(f, 0);  // left fast
    f = '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0};           send_set(f, 0);  // crossing
    f = '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023}; send_set(f, 0);  // hold
    f = '{10'd900, 10'd260, 10'd260, 10'd260, 10'd0};  send_set(f, 0);  // level equals threshold
    drain_and_settle();
  endtask

  // Registers at their extremes, inverted levels and a mode change mid-average.
  task automatic test_register_extremes();
    write_reg(REG_THRESHOLD, 32'd1000);
    write_reg(REG_FAST, 32'd255); write_reg(REG_MEDIUM, 32'd0); write_reg(REG_SLOW, 32'd255);
    write_reg(REG_INVERT, 32'd1);
    for (int k = 0; k < 6; k++) send_set(rand_frame(0, 1023), 0);
    drain_and_settle();
    write_reg(REG_THRESHOLD, 32'd0);
    write_reg(REG_FAST, 32'd0); write_reg(REG_MEDIUM, 32'd255); write_reg(REG_SLOW, 32'd0);
    write_reg(REG_INVERT, 32'd0);
    for (int k = 0; k < 6; k++) send_set(rand_frame(0, 1023), 0);
    drain_and_settle();
    // Two frames in run mode, then the set completes under calibrate mode.
    send_frame(rand_frame(0, 1023), 0); send_frame(rand_frame(0, 1023), 0);
    drain_and_settle();
    write_reg(REG_CAL, 32'd1);
    send_frame(rand_frame(0, 1023), 0); send_frame(rand_frame(0, 1023), 0);
    drain_and_settle();
    write_reg(REG_CAL, 32'd0);
    write_reg(REG_THRESHOLD, 32'd200);
  endtask

  // Receiver holds off long while frames keep coming, so the input stalls.
  task automatic test_backpressure();
    long_stall_req = 1;
    for (int k = 0; k < 10; k++) send_set(rand_frame(0, 1023), 0);
    drain_and_settle();
  endtask

  // Random phases: a further calibration pass, mostly line-like frames, random registers.
  task automatic test_random_phases();
    frame_t f;
    int lo, hi;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_CAL, 32'd1);
      lo = $urandom_range(0, 300); hi = $urandom_range(500, 1023);
      for (int k = 0; k < 3; k++) send_set(rand_frame(lo, hi), 1);
      if (ph == 2) send_set('{10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023}, 1);
      drain_and_settle();
      write_reg(REG_CAL, 32'd0);
      write_reg(REG_THRESHOLD, $urandom_range(0, 1000));
      write_reg(REG_FAST, $urandom_range(0, 255));
      write_reg(REG_MEDIUM, $urandom_range(0, 255));
      write_reg(REG_SLOW, $urandom_range(0, 255));
      write_reg(REG_INVERT, $urandom_range(0, 1));
      for (int k = 0; k < 200; k++) begin
        if ($urandom_range(0, 9) < 8) begin
          // Per-sensor dark or bright with jitter, so rules actually fire.
          for (int i = 0; i < NSENS; i++)
            f[i] = $urandom_range(0, 1) ? 10'($urandom_range(0, 250))
                                        : 10'($urandom_range(650, 1023));
          send_frame(f, 1);
        end else begin
          send_frame(rand_frame(0, 1023), 1);
        end
      end
      drain_and_settle();
    end
  endtask

  initial begin
    reset_predictor();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_calibration();
    test_directed_rules();
    test_register_extremes();
    test_backpressure();
    test_random_phases();
    drain_and_settle();
    $display("Sent %0d sensor frames and checked %0d steering beats across calibrate,",
             sent, checked);
    $display("run, inverted and register-extreme settings, with stalls on both sides.");
    if (mismatches == 0 && steer_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

>>> filelist.f
hdl/lscs_pkg.sv
hdl/lscs_front.sv
hdl/lscs_div.sv
hdl/lscs_back.sv
hdl/line_sensor_calibrate_steer.sv
sim/tb_line_sensor_calibrate_steer.sv
